/* hdl/ptip_pkg.sv */
// shared types, constants and helper functions for the planar tile decoder
package ptip_pkg;

  localparam int unsigned TileAw  = 6;
  localparam int unsigned StoreAw = TileAw + 1;

  typedef enum logic [1:0] {
    DEPTH_2BPP = 2'd0,
    DEPTH_3BPP = 2'd1,
    DEPTH_4BPP = 2'd2,
    DEPTH_8BPP = 2'd3
  } depth_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LAST,
    BK_PUSH
  } back_state_e;

  typedef struct packed {
    logic               en;
    logic [StoreAw-1:0] addr;
    logic [7:0]         data;
  } store_wr_t;

  typedef struct packed {
    logic   err;
    logic   bank;
    depth_e depth;
  } cmd_t;

  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

  typedef struct packed {
    logic [7:0][7:0] pix;
    logic [2:0]      row;
    logic            done;
    logic            err;
  } row_t;

  function automatic logic [TileAw:0] tile_size(depth_e depth);
    logic [TileAw:0] size;
    unique case (depth)
      DEPTH_2BPP: size = 7'd16;
      DEPTH_3BPP: size = 7'd24;
      DEPTH_4BPP: size = 7'd32;
      DEPTH_8BPP: size = 7'd64;
      default:    size = 7'd16;
    endcase
    return size;
  endfunction

  function automatic logic [2:0] last_plane(depth_e depth);
    logic [2:0] p;
    unique case (depth)
      DEPTH_2BPP: p = 3'd1;
      DEPTH_3BPP: p = 3'd2;
      DEPTH_4BPP: p = 3'd3;
      DEPTH_8BPP: p = 3'd7;
      default:    p = 3'd1;
    endcase
    return p;
  endfunction

  // pairs interleave over rows; the lone 3bpp plane sits one byte per row after pair 0
  function automatic logic [TileAw-1:0] plane_addr(depth_e depth, logic [2:0] row,
                                                   logic [2:0] plane);
    logic [TileAw-1:0] a;
    if (depth == DEPTH_3BPP && plane == 3'd2) begin
      a = {3'b010, row};
    end else begin
      a = {plane[2:1], row, plane[0]};
    end
    return a;
  endfunction

endpackage

/* hdl/ptip_fifo.sv */
// two-entry queue used between the decoder stages and at the result side
module ptip_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [1:0][Width-1:0] slot_q;
  logic                  wr_q, wr_d;
  logic                  rd_q, rd_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

/* hdl/ptip_front.sv */
// input side: depth register, byte counting, bank choice and tile/error classification
module ptip_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [7:0]         plane_byte_i,
  input  logic               end_of_data_i,
  output logic               full_o,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_depth_mode_i,
  output ptip_pkg::store_wr_t wr_o,
  output logic               cmd_push_o,
  output ptip_pkg::cmd_t     cmd_o,
  input  logic               cmd_full_i,
  input  ptip_pkg::release_t rel_i
);
  import ptip_pkg::*;

  depth_e            depth_q;
  logic [TileAw-1:0] count_q, count_d;
  logic              bank_q, bank_d;
  logic [1:0]        busy_q, busy_d;
  logic              accept;
  logic [TileAw:0]   received;
  logic              complete;

  assign full_o   = cmd_full_i || busy_q[bank_q];
  assign accept   = push_i && !full_o;
  assign received = {1'b0, count_q} + 7'd1;
  assign complete = (received >= tile_size(depth_q));

  assign wr_o.en   = accept;
  assign wr_o.addr = {bank_q, count_q};
  assign wr_o.data = plane_byte_i;

  assign cmd_push_o = accept && (complete || end_of_data_i);
  assign cmd_o.err   = !complete;
  assign cmd_o.bank  = bank_q;
  assign cmd_o.depth = depth_q;

  always_comb begin
    count_d = count_q;
    bank_d  = bank_q;
    busy_d  = busy_q;
    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (complete) begin
        // finished tile is handed to the back end; keep filling the other bank
        busy_d[bank_q] = 1'b1;
        bank_d         = !bank_q;
        count_d        = '0;
      end else if (end_of_data_i) begin
        count_d = '0;
      end else begin
        count_d = received[TileAw-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_2BPP;
      count_q <= '0;
      bank_q  <= 1'b0;
      busy_q  <= 2'b00;
    end else begin
      if (cfg_valid_i) begin
        depth_q <= depth_e'(cfg_depth_mode_i);
      end
      count_q <= count_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

/* hdl/ptip_back.sv */
// back end: double-banked tile store and the row builder that reads it plane by plane
module ptip_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptip_pkg::store_wr_t wr_i,
  input  logic                cmd_empty_i,
  input  ptip_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output ptip_pkg::release_t  rel_o,
  output logic                row_push_o,
  output ptip_pkg::row_t      row_o,
  input  logic                row_full_i
);
  import ptip_pkg::*;

  logic [7:0] mem [2**StoreAw];

  back_state_e       state_q, state_d;
  logic [2:0]        row_q, row_d;
  logic [2:0]        plane_q, plane_d;
  logic              rd_en;
  logic [StoreAw-1:0] rd_addr;
  logic [7:0]        rdata_q;
  logic              rd_vld_q;
  logic [2:0]        rd_plane_q;
  logic [7:0][7:0]   acc_q, acc_d;
  logic              err_q, err_d;
  logic              clear_acc;

  assign rd_addr = {cmd_i.bank, plane_addr(cmd_i.depth, row_q, plane_q)};

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    plane_d    = plane_q;
    err_d      = err_q;
    rd_en      = 1'b0;
    clear_acc  = 1'b0;
    cmd_pop_o  = 1'b0;
    rel_o.en   = 1'b0;
    rel_o.bank = cmd_i.bank;
    row_push_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          row_d   = '0;
          plane_d = '0;
          err_d   = cmd_i.err;
          if (cmd_i.err) begin
            clear_acc = 1'b1;
            state_d   = BK_PUSH;
          end else begin
            state_d = BK_READ;
          end
        end
      end
      BK_READ: begin
        rd_en = 1'b1;
        if (plane_q == last_plane(cmd_i.depth)) begin
          state_d = BK_LAST;
        end else begin
          plane_d = plane_q + 3'd1;
        end
      end
      BK_LAST: begin
        state_d = BK_PUSH;
      end
      BK_PUSH: begin
        if (!row_full_i) begin
          row_push_o = 1'b1;
          if (err_q || row_q == 3'd7) begin
            cmd_pop_o = 1'b1;
            rel_o.en  = !err_q;
            state_d   = BK_IDLE;
          end else begin
            row_d   = row_q + 3'd1;
            plane_d = '0;
            state_d = BK_READ;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // plane p of the row lands in bit p of every pixel; bit 7 of a byte is the left pixel
  always_comb begin
    acc_d = acc_q;
    if (clear_acc) begin
      acc_d = '0;
    end else if (rd_vld_q) begin
      for (int c = 0; c < 8; c++) begin
        if (rd_plane_q == 3'd0) begin
          acc_d[c] = '0;
        end
        acc_d[c][rd_plane_q] = rdata_q[7-c];
      end
    end
  end

  assign row_o.pix  = acc_q;
  assign row_o.row  = row_q;
  assign row_o.done = !err_q && (row_q == 3'd7);
  assign row_o.err  = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      row_q    <= '0;
      plane_q  <= '0;
      err_q    <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      plane_q  <= plane_d;
      err_q    <= err_d;
      rd_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    rd_plane_q <= plane_q;
    acc_q      <= acc_d;
  end

endmodule

/* hdl/planar_tile_to_indexed_pixels.sv */
// Planar 8x8 tile to indexed pixel decoder, 2/3/4/8 bits per pixel. Bytes are taken one per
// cycle into one bank of a two-bank tile store while the other bank is being decoded; a
// finished tile (or a stream that ends partway through one) is queued to the row builder.
// The row builder has a single store read port and reads one plane byte per cycle. Input
// stalls (full high) when both banks hold tiles not yet decoded, or when two tile or early-end
// commands are already waiting for the row builder. Rows come out top to bottom, tile_done
// marks row 7, and an early end of stream gives one result with length_error set and zero
// pixels. depth_mode may be changed whenever the block is idle.
module planar_tile_to_indexed_pixels (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] plane_byte_i,
  input  logic       end_of_data_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] pixel_0_o,
  output logic [7:0] pixel_1_o,
  output logic [7:0] pixel_2_o,
  output logic [7:0] pixel_3_o,
  output logic [7:0] pixel_4_o,
  output logic [7:0] pixel_5_o,
  output logic [7:0] pixel_6_o,
  output logic [7:0] pixel_7_o,
  output logic [2:0] row_number_o,
  output logic       tile_done_o,
  output logic       length_error_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_depth_mode_i
);
  import ptip_pkg::*;

  store_wr_t wr;
  release_t  rel;
  cmd_t      cmd_in, cmd_out;
  logic      cmd_push, cmd_pop, cmd_full, cmd_empty;
  row_t      row_in, row_out;
  logic      row_push, row_full;

  assign cfg_ready_o = 1'b1;

  ptip_front u_front (
    .clk_i,
    .rst_ni,
    .push_i           (push),
    .plane_byte_i,
    .end_of_data_i,
    .full_o           (full),
    .cfg_valid_i,
    .cfg_depth_mode_i,
    .wr_o             (wr),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_in),
    .cmd_full_i       (cmd_full),
    .rel_i            (rel)
  );

  ptip_fifo #(.Width($bits(cmd_t))) u_cmd_q (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  ptip_back u_back (
    .clk_i,
    .rst_ni,
    .wr_i        (wr),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .rel_o       (rel),
    .row_push_o  (row_push),
    .row_o       (row_in),
    .row_full_i  (row_full)
  );

  ptip_fifo #(.Width($bits(row_t))) u_row_q (
    .clk_i,
    .rst_ni,
    .push_i  (row_push),
    .data_i  (row_in),
    .full_o  (row_full),
    .pop_i   (pop),
    .data_o  (row_out),
    .empty_o (empty)
  );

  assign pixel_0_o      = row_out.pix[0];
  assign pixel_1_o      = row_out.pix[1];
  assign pixel_2_o      = row_out.pix[2];
  assign pixel_3_o      = row_out.pix[3];
  assign pixel_4_o      = row_out.pix[4];
  assign pixel_5_o      = row_out.pix[5];
  assign pixel_6_o      = row_out.pix[6];
  assign pixel_7_o      = row_out.pix[7];
  assign row_number_o   = row_out.row;
  assign tile_done_o    = row_out.done;
  assign length_error_o = row_out.err;

endmodule

/* hdl/ptip_checker.sv */
// port-level checks on the decoder's result stream, bound to the top level
module ptip_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic [7:0] plane_byte_i,
  input logic       end_of_data_i,
  input logic       empty,
  input logic       pop,
  input logic [7:0] pixel_0_o,
  input logic [7:0] pixel_1_o,
  input logic [7:0] pixel_2_o,
  input logic [7:0] pixel_3_o,
  input logic [7:0] pixel_4_o,
  input logic [7:0] pixel_5_o,
  input logic [7:0] pixel_6_o,
  input logic [7:0] pixel_7_o,
  input logic [2:0] row_number_o,
  input logic       tile_done_o,
  input logic       length_error_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [1:0] cfg_depth_mode_i
);

  // an error beat carries no pixels and no row
  a_err_beat_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && length_error_o) |->
      (pixel_0_o == 8'd0 && pixel_1_o == 8'd0 && pixel_2_o == 8'd0 && pixel_3_o == 8'd0 &&
       pixel_4_o == 8'd0 && pixel_5_o == 8'd0 && pixel_6_o == 8'd0 && pixel_7_o == 8'd0 &&
       row_number_o == 3'd0 && !tile_done_o))
    else $error("error beat with non-zero payload");

  a_done_on_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && tile_done_o) |-> (row_number_o == 3'd7 && !length_error_o))
    else $error("tile_done on a row other than the last");

  // rows of one tile follow each other without gaps or repeats
  a_row_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !tile_done_o && !length_error_o) ##1 !empty |->
      (row_number_o == 3'($past(row_number_o) + 3'd1) && !length_error_o))
    else $error("row sequence broken inside a tile");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(row_number_o) && $stable(pixel_0_o)))
    else $error("waiting result changed");

endmodule

bind planar_tile_to_indexed_pixels ptip_checker u_ptip_checker (.*);
